// ----- src/multichannel_delayed_pulse_timer_defines.svh -----
// assertion helpers for the pulse timer
`ifndef MULTICHANNEL_DELAYED_PULSE_TIMER_DEFINES_SVH
`define MULTICHANNEL_DELAYED_PULSE_TIMER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MDPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdpt assertion failed");

// next-cycle implication, disabled while in reset
`define MDPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdpt assertion failed");

`endif

// ----- src/mdpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mdpt_pkg;

  localparam int CHANNELS_DEF  = 32;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths
  localparam int CMD_W      = 1;
  localparam int CH_FIELD_W = 8;
  localparam int LEN_W      = 24;
  localparam int LEN_IDX_W  = $clog2(LEN_W);
  localparam int DRIVE_W    = 32;

  localparam logic [CMD_W-1:0] CMD_TICK  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SCHED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_SCAN_BIT,
    ST_SCAN_CH,
    ST_SCHED_ADD,
    ST_SCHED_RING,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- src/mdpt_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface mdpt_in_if;
  logic                              valid;
  logic                              ready;
  logic [mdpt_pkg::CMD_W-1:0]        command;
  logic [mdpt_pkg::CH_FIELD_W-1:0]   channel;
  logic [mdpt_pkg::LEN_W-1:0]        wait_ms;
  logic [mdpt_pkg::LEN_W-1:0]        length_ms;

  modport source (output valid, command, channel, wait_ms, length_ms, input ready);
  modport sink   (input valid, command, channel, wait_ms, length_ms, output ready);
endinterface

`default_nettype wire

// ----- src/mdpt_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface mdpt_out_if;
  logic                           valid;
  logic                           ready;
  logic [mdpt_pkg::DRIVE_W-1:0]   drive_bits;
  logic                           accepted;

  modport source (output valid, drive_bits, accepted, input ready);
  modport sink   (input valid, drive_bits, accepted, output ready);
endinterface

`default_nettype wire

// ----- src/multichannel_delayed_pulse_timer.sv -----
// channel    direction  payload
// in_item    sink       command, channel, wait_ms, length_ms
// out_res    source     drive_bits, accepted
//
// one item at a time; a tick increments the clock bit-serially, then runs a bit-serial compare
// over every channel record in turn; a schedule adds the wait to the clock bit-serially, then
// passes once round the ring, and an invalid schedule goes straight to the result
// rst_n is synchronous and clears the clock, every channel record and the drive levels
// a new item is taken while the previous result still waits in the output register
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_delayed_pulse_timer_defines.svh"

module multichannel_delayed_pulse_timer #(
  parameter int CHANNELS  = mdpt_pkg::CHANNELS_DEF,
  parameter int TIME_BITS = mdpt_pkg::TIME_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  mdpt_in_if.sink      in_item,
  mdpt_out_if.source   out_res
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BIT_W = $clog2(TIME_BITS);
  localparam logic [CH_W-1:0]  CH_LAST  = CH_W'(CHANNELS - 1);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(TIME_BITS - 1);
  localparam int LEN_W = mdpt_pkg::LEN_W;

  mdpt_pkg::state_t state_r, state_nxt;

  // control and serial arithmetic
  logic [BIT_W-1:0]     bit_cnt_r;
  logic [CH_W-1:0]      ch_cnt_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TIME_BITS-1:0] sum_r;
  logic                 carry_r;
  logic                 ge_dl_r;
  logic                 ge_len_r;
  logic                 bor_r;

  // captured schedule item
  logic [CH_W-1:0]      item_k_r;
  logic [LEN_W-1:0]     item_wait_r;
  logic [LEN_W-1:0]     item_len_r;
  logic                 acc_r;

  // channel record ring, entry 0 is the head under processing
  logic [TIME_BITS-1:0] dl_r  [CHANNELS];
  logic [TIME_BITS-1:0] ons_r [CHANNELS];
  logic [LEN_W-1:0]     len_r [CHANNELS];
  logic [CHANNELS-1:0]  act_r;
  logic [CHANNELS-1:0]  drv_r;

  // output register
  logic                          out_valid_r;
  logic [mdpt_pkg::DRIVE_W-1:0]  out_drive_r;
  logic                          out_acc_r;
  logic [mdpt_pkg::DRIVE_W-1:0]  drive_w;

  logic bit_last, ch_last, ch_ok, in_take;
  logic ring_shift, bit_rot;
  logic nb, db, ob, lb, diff_b;
  logic len_nz, len_hi_nz, start_w, stop_w;
  logic [TIME_BITS-1:0] head_dl_nxt, head_ons_nxt;
  logic [LEN_W-1:0]     head_len_nxt;
  logic                 head_act_nxt;

  assign bit_last = (bit_cnt_r == BIT_LAST);
  assign ch_last  = (ch_cnt_r == CH_LAST);
  assign ch_ok    = (in_item.channel != '0) &&
                    (in_item.channel <= mdpt_pkg::CH_FIELD_W'(CHANNELS));
  assign in_item.ready = (state_r == mdpt_pkg::ST_IDLE);
  assign in_take  = in_item.valid && in_item.ready;

  assign ring_shift = (state_r == mdpt_pkg::ST_SCAN_CH) ||
                      (state_r == mdpt_pkg::ST_SCHED_RING);
  assign bit_rot    = (state_r == mdpt_pkg::ST_SCAN_BIT);

  // serial bits, lsb first; the clock and head deadline and onset rotate right each bit step
  assign nb     = now_r[0];
  assign db     = dl_r[0][0];
  assign ob     = ons_r[0][0];
  assign lb     = (32'(bit_cnt_r) < LEN_W) ?
                  len_r[0][mdpt_pkg::LEN_IDX_W'(bit_cnt_r)] : 1'b0;
  assign diff_b = nb ^ ob ^ bor_r;

  // length bits beyond the clock width mean the pulse never runs out
  assign len_nz    = (len_r[0] != '0);
  assign len_hi_nz = ((len_r[0] >> TIME_BITS) != '0);

  // start and stop exclude each other: a start needs an inactive channel, a stop an active one
  assign start_w = !act_r[0] && ge_dl_r && len_nz;
  assign stop_w  = act_r[0] && ge_len_r && !len_hi_nz;

  // record written back at the tail of the ring
  always_comb begin
    head_dl_nxt  = dl_r[0];
    head_ons_nxt = ons_r[0];
    head_len_nxt = len_r[0];
    head_act_nxt = act_r[0];
    if (state_r == mdpt_pkg::ST_SCAN_CH) begin
      if (start_w) begin
        head_ons_nxt = now_r;
        head_act_nxt = 1'b1;
      end else if (stop_w) begin
        head_ons_nxt = '0;
        head_len_nxt = '0;
        head_act_nxt = 1'b0;
      end
    end else if (ch_cnt_r == item_k_r) begin
      // schedule pass: replace the named channel
      head_dl_nxt  = sum_r;
      head_len_nxt = item_len_r;
      head_act_nxt = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mdpt_pkg::ST_IDLE: begin
        if (in_item.valid) begin
          if (in_item.command == mdpt_pkg::CMD_TICK) begin
            state_nxt = mdpt_pkg::ST_INC;
          end else if (ch_ok) begin
            state_nxt = mdpt_pkg::ST_SCHED_ADD;
          end else begin
            state_nxt = mdpt_pkg::ST_DONE;
          end
        end
      end
      mdpt_pkg::ST_INC: begin
        if (bit_last) state_nxt = mdpt_pkg::ST_SCAN_BIT;
      end
      mdpt_pkg::ST_SCAN_BIT: begin
        if (bit_last) state_nxt = mdpt_pkg::ST_SCAN_CH;
      end
      mdpt_pkg::ST_SCAN_CH: begin
        state_nxt = ch_last ? mdpt_pkg::ST_DONE : mdpt_pkg::ST_SCAN_BIT;
      end
      mdpt_pkg::ST_SCHED_ADD: begin
        if (bit_last) state_nxt = mdpt_pkg::ST_SCHED_RING;
      end
      mdpt_pkg::ST_SCHED_RING: begin
        if (ch_last) state_nxt = mdpt_pkg::ST_DONE;
      end
      mdpt_pkg::ST_DONE: begin
        if (!out_valid_r || out_res.ready) state_nxt = mdpt_pkg::ST_IDLE;
      end
      default: state_nxt = mdpt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // counters, clock and serial flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r   <= '0;
      ch_cnt_r    <= '0;
      now_r       <= '0;
      carry_r     <= 1'b0;
      ge_dl_r     <= 1'b1;
      ge_len_r    <= 1'b1;
      bor_r       <= 1'b0;
      drv_r       <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may replace one that transfers in the same cycle
      if ((state_r == mdpt_pkg::ST_DONE) && (!out_valid_r || out_res.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_take) begin
        acc_r     <= (in_item.command == mdpt_pkg::CMD_SCHED) && ch_ok;
        carry_r   <= (in_item.command == mdpt_pkg::CMD_TICK);
        bit_cnt_r <= '0;
      end

      if ((state_r == mdpt_pkg::ST_INC) || (state_r == mdpt_pkg::ST_SCAN_BIT) ||
          (state_r == mdpt_pkg::ST_SCHED_ADD)) begin
        bit_cnt_r <= bit_last ? '0 : bit_cnt_r + 1'b1;
      end

      if (state_r == mdpt_pkg::ST_INC) begin
        // serial increment
        now_r   <= {nb ^ carry_r, now_r[TIME_BITS-1:1]};
        carry_r <= nb & carry_r;
        if (bit_last) begin
          ch_cnt_r <= '0;
          ge_dl_r  <= 1'b1;
          ge_len_r <= 1'b1;
          bor_r    <= 1'b0;
        end
      end

      if (state_r == mdpt_pkg::ST_SCAN_BIT) begin
        now_r <= {nb, now_r[TIME_BITS-1:1]};
        if (nb != db) ge_dl_r <= nb;
        if (diff_b != lb) ge_len_r <= diff_b;
        bor_r <= (!nb && ob) || (!(nb ^ ob) && bor_r);
      end

      if (state_r == mdpt_pkg::ST_SCAN_CH) begin
        if (start_w) drv_r[ch_cnt_r] <= 1'b1;
        else if (stop_w) drv_r[ch_cnt_r] <= 1'b0;
        ch_cnt_r <= ch_last ? '0 : ch_cnt_r + 1'b1;
        ge_dl_r  <= 1'b1;
        ge_len_r <= 1'b1;
        bor_r    <= 1'b0;
      end

      if (state_r == mdpt_pkg::ST_SCHED_ADD) begin
        // clock keeps its value, carry starts clear
        now_r   <= {nb, now_r[TIME_BITS-1:1]};
        carry_r <= (nb & item_wait_r[0]) | (nb & carry_r) | (item_wait_r[0] & carry_r);
        if (bit_last) ch_cnt_r <= '0;
      end

      if (state_r == mdpt_pkg::ST_SCHED_RING) begin
        ch_cnt_r <= ch_last ? '0 : ch_cnt_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_k_r    <= CH_W'(in_item.channel - 1'b1);
      item_wait_r <= in_item.wait_ms;
      item_len_r  <= in_item.length_ms;
    end else if (state_r == mdpt_pkg::ST_SCHED_ADD) begin
      item_wait_r <= {1'b0, item_wait_r[LEN_W-1:1]};
    end
    if (state_r == mdpt_pkg::ST_SCHED_ADD) begin
      sum_r <= {nb ^ item_wait_r[0] ^ carry_r, sum_r[TIME_BITS-1:1]};
    end
    if ((state_r == mdpt_pkg::ST_DONE) && (!out_valid_r || out_res.ready)) begin
      out_drive_r <= drive_w;
      out_acc_r   <= acc_r;
    end
  end

  // ring of channel records; a full pass returns it to channel order
  for (genvar i = 0; i < CHANNELS; i++) begin : g_ring
    logic [TIME_BITS-1:0] src_dl, src_ons;
    logic [LEN_W-1:0]     src_len;
    logic                 src_act;

    if (i == CHANNELS - 1) begin : g_tail
      assign src_dl  = head_dl_nxt;
      assign src_ons = head_ons_nxt;
      assign src_len = head_len_nxt;
      assign src_act = head_act_nxt;
    end else begin : g_mid
      assign src_dl  = dl_r[i+1];
      assign src_ons = ons_r[i+1];
      assign src_len = len_r[i+1];
      assign src_act = act_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dl_r[i]  <= '0;
        ons_r[i] <= '0;
        len_r[i] <= '0;
        act_r[i] <= 1'b0;
      end else if (ring_shift) begin
        dl_r[i]  <= src_dl;
        ons_r[i] <= src_ons;
        len_r[i] <= src_len;
        act_r[i] <= src_act;
      end else if (bit_rot && (i == 0)) begin
        dl_r[i]  <= {dl_r[i][0], dl_r[i][TIME_BITS-1:1]};
        ons_r[i] <= {ons_r[i][0], ons_r[i][TIME_BITS-1:1]};
      end
    end
  end

  // visible drive levels, channels beyond the field width are hidden
  for (genvar n = 0; n < mdpt_pkg::DRIVE_W; n++) begin : g_drive
    if (n < CHANNELS) begin : g_on
      assign drive_w[n] = drv_r[n];
    end else begin : g_off
      assign drive_w[n] = 1'b0;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.drive_bits = out_drive_r;
  assign out_res.accepted   = out_acc_r;

  // an active channel always has its output on while the ring is aligned
  `MDPT_ASSERT_IMP(a_active_drives, state_r == mdpt_pkg::ST_IDLE, (act_r & ~drv_r) == '0)
  // a transfer on the input always starts work
  `MDPT_ASSERT_NXT(a_busy_after_take, in_take, state_r != mdpt_pkg::ST_IDLE)
  // a result appears only from the finishing state
  `MDPT_ASSERT_IMP(a_out_from_done, $rose(out_res.valid), $past(state_r) == mdpt_pkg::ST_DONE)
  // every channel compare starts from fresh serial flags
  `MDPT_ASSERT_IMP(a_flags_fresh, (state_r == mdpt_pkg::ST_SCAN_BIT) && (bit_cnt_r == '0), ge_dl_r && ge_len_r && !bor_r)

endmodule

`default_nettype wire
